### rtl/fls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fls_pkg
// shared constants for the flag state sync link: field widths, op and
// register codes, parse phases and register reset values
// ============================================================================
package fls_pkg;

    // built maximum of entries
    localparam int FLS_MAX_ENTRIES = 8;

    // field widths
    localparam int OP_W        = 2;
    localparam int ENTRY_W     = 3;
    localparam int BYTE_W      = 8;
    localparam int NUM_ENT_W   = 4;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int FLAGS_W     = 8;
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 48;
    localparam int M_PAD_W     = M_TDATA_W - (1 + BYTE_W + 4 * FLAGS_W);
    localparam int S_PAD_W     = S_TDATA_W - (ENTRY_W + 1 + BYTE_W);

    // input operations
    localparam logic [OP_W-1:0] OP_SET_IGNITE = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_FIRE   = 2'd1;
    localparam logic [OP_W-1:0] OP_RX_BYTE    = 2'd2;
    localparam logic [OP_W-1:0] OP_TRANSMIT   = 2'd3;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_ENTRIES = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_START_CODE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_CODE   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ACK_CODE    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_END_CODE    = 3'd4;

    // register reset values
    localparam logic [NUM_ENT_W-1:0] RST_NUM_ENTRIES = 4'd8;
    localparam logic [BYTE_W-1:0]    RST_START_CODE  = 8'd126;
    localparam logic [BYTE_W-1:0]    RST_BASE_CODE   = 8'd65;
    localparam logic [BYTE_W-1:0]    RST_ACK_CODE    = 8'd33;
    localparam logic [BYTE_W-1:0]    RST_END_CODE    = 8'd10;

    // receive parser phases
    typedef logic [1:0] phase_t;
    localparam phase_t PHASE_HUNT = 2'd0;
    localparam phase_t PHASE_SEQ  = 2'd1;
    localparam phase_t PHASE_BODY = 2'd2;

endpackage : fls_pkg
`default_nettype wire

### rtl/flag_state_sync_link.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// flag_state_sync_link
// ignite / fire flag keeper with a byte framed sync link: flag changes bump
// a wrapping change sequence, transmit requests send the flag state as a
// frame while the partner lags, received data frames are parsed, committed and acknowledged
// ============================================================================
//
//  channel   direction  handshake           payload
//  s_        in         s_tvalid/s_tready   s_tdata, s_tuser (op)
//  m_        out        m_tvalid/m_tready   m_tdata, m_tlast (last byte)
//  cfg_      in         cfg_wr_en           cfg_addr, cfg_wr_data
//
//  a set op or a hunt / sequence byte completes in the cycle it is accepted;
//  a frame body byte is classified in the shared add/subtract unit, a fire code then indexed there
//  a closing byte of a data frame then sends the ack frame: start, sequence, ack, end
//  a transmit sends start, sequence, the code of each set ignite flag of the
//  entries in use, then the code of each set fire flag, then end
//  m_tready low holds the sequencer on the byte waiting for the output slot
//  reset (synchronous, aresetn low) clears all flags, sequences and the
//  parser; there is no clearing pass
//
module flag_state_sync_link import fls_pkg::*; #(
    parameter int MAX_ENTRIES = FLS_MAX_ENTRIES
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [2:0] entry_index, [3] turn_on, [11:4] rx_byte, [15:12] zero
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // [1:0] op
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] byte_valid, [8:1] tx_byte, [16:9] ignite_flags, [24:17] fire_flags,
    // [32:25] change_sequence, [40:33] acked_sequence, [47:41] zero
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tlast,
    // configuration writes
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int IDX_W  = $clog2(MAX_ENTRIES + 1);
    localparam int OFF_W  = $clog2(2 * MAX_ENTRIES + 1);
    localparam int ALU_W  = ((OFF_W > BYTE_W) ? OFF_W : BYTE_W) + 2;
    localparam int NCMP_W = (IDX_W > NUM_ENT_W) ? IDX_W : NUM_ENT_W;
    localparam int E_W    = (IDX_W > ENTRY_W) ? IDX_W : ENTRY_W;
    localparam int VIS_W  = (MAX_ENTRIES > FLAGS_W) ? MAX_ENTRIES : FLAGS_W;

    // sequencer states
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_RX_CLASS  = 4'd1;
    localparam logic [3:0] ST_RX_FIRE   = 4'd2;
    localparam logic [3:0] ST_TX_START  = 4'd3;
    localparam logic [3:0] ST_TX_SEQ    = 4'd4;
    localparam logic [3:0] ST_TX_IGN    = 4'd5;
    localparam logic [3:0] ST_TX_FIRE   = 4'd6;
    localparam logic [3:0] ST_TX_END    = 4'd7;
    localparam logic [3:0] ST_ACK_START = 4'd8;
    localparam logic [3:0] ST_ACK_SEQ   = 4'd9;
    localparam logic [3:0] ST_ACK_ACK   = 4'd10;
    localparam logic [3:0] ST_ACK_END   = 4'd11;

    // configuration registers
    logic [NUM_ENT_W-1:0] num_entries_reg;
    logic [BYTE_W-1:0]    start_code_reg, base_code_reg, ack_code_reg, end_code_reg;

    // link state
    logic [3:0]             state_reg, state_next;
    logic [MAX_ENTRIES-1:0] ign_reg, ign_next;
    logic [MAX_ENTRIES-1:0] fire_reg, fire_next;
    logic [MAX_ENTRIES-1:0] pend_ign_reg, pend_ign_next;
    logic [MAX_ENTRIES-1:0] pend_fire_reg, pend_fire_next;
    logic [BYTE_W-1:0]      local_seq_reg, local_seq_next;
    logic [BYTE_W-1:0]      acked_reg, acked_next;
    logic [BYTE_W-1:0]      frame_seq_reg, frame_seq_next;
    phase_t                 phase_reg, phase_next;
    logic                   ack_seen_reg, ack_seen_next;
    logic [BYTE_W-1:0]      byte_reg, byte_next;
    logic [OFF_W-1:0]       diff_reg, diff_next;
    logic [IDX_W-1:0]       cnt_reg, cnt_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]   m_byte_reg, m_byte_next;
    logic                m_last_reg, m_last_next;
    logic [FLAGS_W-1:0]  m_ign_reg, m_ign_next;
    logic [FLAGS_W-1:0]  m_fire_reg, m_fire_next;
    logic [BYTE_W-1:0]   m_seq_reg, m_seq_next;
    logic [BYTE_W-1:0]   m_acked_reg, m_acked_next;

    // input fields
    logic [OP_W-1:0]    in_op;
    logic [ENTRY_W-1:0] in_entry;
    logic               in_on;
    logic [BYTE_W-1:0]  in_byte;
    logic               in_xfer;

    // shared unit
    logic [ALU_W-1:0] alu_a, alu_b, alu_res;
    logic             alu_sub;
    logic             alu_neg;

    // helpers
    logic [NCMP_W-1:0]      n_cmp;
    logic [IDX_W-1:0]       n_eff;
    logic [MAX_ENTRIES-1:0] use_mask;
    logic [MAX_ENTRIES-1:0] set_sel;
    logic [MAX_ENTRIES-1:0] res_sel;
    logic [MAX_ENTRIES-1:0] cnt_sel;
    logic [E_W-1:0]         in_idx_w;
    logic                   set_hit;
    logic                   set_cur;
    logic                   out_free;
    logic                   load;
    logic [BYTE_W-1:0]      load_byte;
    logic                   load_last;
    logic [VIS_W-1:0]       ign_vis, fire_vis;
    logic                   ign_hit, fire_hit;

    assign in_entry = s_tdata[ENTRY_W-1:0];
    assign in_on    = s_tdata[ENTRY_W];
    assign in_byte  = s_tdata[ENTRY_W+BYTE_W:ENTRY_W+1];
    assign in_op    = s_tuser[OP_W-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // entries in use, clamped to the built maximum
    always_comb begin
        n_cmp = NCMP_W'(num_entries_reg);
        if (n_cmp > NCMP_W'(MAX_ENTRIES)) begin
            n_eff = IDX_W'(MAX_ENTRIES);
        end else begin
            n_eff = IDX_W'(n_cmp);
        end
    end

    // per entry selects
    always_comb begin
        in_idx_w = E_W'(in_entry);
        set_hit  = in_idx_w < E_W'(n_eff);
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            use_mask[i] = IDX_W'(i) < n_eff;
            set_sel[i]  = set_hit && (in_idx_w == E_W'(i));
            res_sel[i]  = (alu_res == ALU_W'(i));
            cnt_sel[i]  = (cnt_reg == IDX_W'(i));
        end
    end

    // shared add / subtract operand select
    always_comb begin
        alu_a   = ALU_W'(base_code_reg);
        alu_b   = ALU_W'(cnt_reg);
        alu_sub = 1'b0;
        case (state_reg)
            ST_RX_CLASS: begin
                alu_a   = ALU_W'(byte_reg);
                alu_b   = ALU_W'(base_code_reg);
                alu_sub = 1'b1;
            end
            ST_RX_FIRE: begin
                alu_a   = ALU_W'(diff_reg);
                alu_b   = ALU_W'(n_eff);
                alu_sub = 1'b1;
            end
            ST_TX_FIRE: begin
                alu_b = ALU_W'(n_eff) + ALU_W'(cnt_reg);
            end
            default: begin
                alu_b = ALU_W'(cnt_reg);
            end
        endcase
    end

    fls_alu #(
        .ALU_W (ALU_W)
    ) u_alu (
        .op_a   (alu_a),
        .op_b   (alu_b),
        .op_sub (alu_sub),
        .result (alu_res)
    );

    assign alu_neg  = alu_res[ALU_W-1];
    // body byte classification against the ignite and fire code ranges
    assign ign_hit  = !alu_neg && (alu_res < ALU_W'(n_eff));
    assign fire_hit = !alu_neg && !ign_hit && (alu_res < ALU_W'({n_eff, 1'b0}));

    // committed flags of entries in use, as shown on the output
    assign ign_vis  = VIS_W'(ign_reg & use_mask);
    assign fire_vis = VIS_W'(fire_reg & use_mask);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        ign_next       = ign_reg;
        fire_next      = fire_reg;
        pend_ign_next  = pend_ign_reg;
        pend_fire_next = pend_fire_reg;
        local_seq_next = local_seq_reg;
        acked_next     = acked_reg;
        frame_seq_next = frame_seq_reg;
        phase_next     = phase_reg;
        ack_seen_next  = ack_seen_reg;
        byte_next      = byte_reg;
        diff_next      = diff_reg;
        cnt_next       = cnt_reg;
        load           = 1'b0;
        load_byte      = start_code_reg;
        load_last      = 1'b0;
        set_cur        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    byte_next = in_byte;
                    case (in_op)
                        OP_SET_IGNITE: begin
                            set_cur = |(ign_reg & set_sel);
                            if (set_hit && (set_cur != in_on)) begin
                                ign_next       = in_on ? (ign_reg | set_sel)
                                                       : (ign_reg & ~set_sel);
                                local_seq_next = local_seq_reg + 8'd1;
                            end
                        end
                        OP_SET_FIRE: begin
                            set_cur = |(fire_reg & set_sel);
                            if (set_hit && (set_cur != in_on)) begin
                                fire_next      = in_on ? (fire_reg | set_sel)
                                                       : (fire_reg & ~set_sel);
                                local_seq_next = local_seq_reg + 8'd1;
                            end
                        end
                        OP_RX_BYTE: begin
                            case (phase_reg)
                                PHASE_SEQ: begin
                                    frame_seq_next = in_byte;
                                    ack_seen_next  = 1'b0;
                                    phase_next     = PHASE_BODY;
                                end
                                PHASE_BODY: begin
                                    state_next = ST_RX_CLASS;
                                end
                                default: begin
                                    phase_next = (in_byte == start_code_reg) ? PHASE_SEQ
                                                                             : PHASE_HUNT;
                                end
                            endcase
                        end
                        default: begin
                            // transmit only while the partner lags behind
                            if (local_seq_reg != acked_reg) begin
                                state_next = ST_TX_START;
                            end
                        end
                    endcase
                end
            end

            ST_RX_CLASS: begin
                state_next = ST_IDLE;
                if (ign_hit) begin
                    pend_ign_next = pend_ign_reg | res_sel;
                end else if (fire_hit) begin
                    diff_next  = OFF_W'(alu_res);
                    state_next = ST_RX_FIRE;
                end else if (byte_reg == ack_code_reg) begin
                    acked_next    = frame_seq_reg;
                    ack_seen_next = 1'b1;
                end else if (byte_reg == end_code_reg) begin
                    phase_next = PHASE_HUNT;
                    if (!ack_seen_reg) begin
                        // commit the pending set and answer with an ack frame
                        ign_next       = (ign_reg & ~use_mask) | (pend_ign_reg & use_mask);
                        fire_next      = (fire_reg & ~use_mask) | (pend_fire_reg & use_mask);
                        pend_ign_next  = pend_ign_reg & ~use_mask;
                        pend_fire_next = pend_fire_reg & ~use_mask;
                        state_next     = ST_ACK_START;
                    end
                end else begin
                    pend_ign_next  = pend_ign_reg & ~use_mask;
                    pend_fire_next = pend_fire_reg & ~use_mask;
                end
            end

            ST_RX_FIRE: begin
                // unit yields the fire code's entry index
                pend_fire_next = pend_fire_reg | res_sel;
                state_next     = ST_IDLE;
            end

            ST_TX_START: begin
                if (out_free) begin
                    load       = 1'b1;
                    load_byte  = start_code_reg;
                    state_next = ST_TX_SEQ;
                end
            end

            ST_TX_SEQ: begin
                if (out_free) begin
                    load       = 1'b1;
                    load_byte  = local_seq_reg;
                    cnt_next   = '0;
                    state_next = ST_TX_IGN;
                end
            end

            ST_TX_IGN: begin
                if (cnt_reg == n_eff) begin
                    cnt_next   = '0;
                    state_next = ST_TX_FIRE;
                end else if (|(ign_reg & cnt_sel)) begin
                    if (out_free) begin
                        load      = 1'b1;
                        load_byte = alu_res[BYTE_W-1:0];
                        cnt_next  = cnt_reg + IDX_W'(1);
                    end
                end else begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end

            ST_TX_FIRE: begin
                if (cnt_reg == n_eff) begin
                    state_next = ST_TX_END;
                end else if (|(fire_reg & cnt_sel)) begin
                    if (out_free) begin
                        load      = 1'b1;
                        load_byte = alu_res[BYTE_W-1:0];
                        cnt_next  = cnt_reg + IDX_W'(1);
                    end
                end else begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end

            ST_TX_END: begin
                if (out_free) begin
                    load       = 1'b1;
                    load_byte  = end_code_reg;
                    load_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_ACK_START: begin
                if (out_free) begin
                    load       = 1'b1;
                    load_byte  = start_code_reg;
                    state_next = ST_ACK_SEQ;
                end
            end

            ST_ACK_SEQ: begin
                if (out_free) begin
                    load       = 1'b1;
                    load_byte  = frame_seq_reg;
                    state_next = ST_ACK_ACK;
                end
            end

            ST_ACK_ACK: begin
                if (out_free) begin
                    load       = 1'b1;
                    load_byte  = ack_code_reg;
                    state_next = ST_ACK_END;
                end
            end

            ST_ACK_END: begin
                if (out_free) begin
                    load       = 1'b1;
                    load_byte  = end_code_reg;
                    load_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output slot: a loaded byte snapshots the status fields
    always_comb begin
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        m_ign_next   = m_ign_reg;
        m_fire_next  = m_fire_reg;
        m_seq_next   = m_seq_reg;
        m_acked_next = m_acked_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next = 1'b1;
            m_byte_next  = load_byte;
            m_last_next  = load_last;
            m_ign_next   = ign_vis[FLAGS_W-1:0];
            m_fire_next  = fire_vis[FLAGS_W-1:0];
            m_seq_next   = local_seq_reg;
            m_acked_next = acked_reg;
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ign_reg       <= '0;
            fire_reg      <= '0;
            pend_ign_reg  <= '0;
            pend_fire_reg <= '0;
            local_seq_reg <= '0;
            acked_reg     <= '0;
            frame_seq_reg <= '0;
            phase_reg     <= PHASE_HUNT;
            ack_seen_reg  <= 1'b0;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ign_reg       <= ign_next;
            fire_reg      <= fire_next;
            pend_ign_reg  <= pend_ign_next;
            pend_fire_reg <= pend_fire_next;
            local_seq_reg <= local_seq_next;
            acked_reg     <= acked_next;
            frame_seq_reg <= frame_seq_next;
            phase_reg     <= phase_next;
            ack_seen_reg  <= ack_seen_next;
            cnt_reg       <= cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        diff_reg    <= diff_next;
        m_byte_reg  <= m_byte_next;
        m_last_reg  <= m_last_next;
        m_ign_reg   <= m_ign_next;
        m_fire_reg  <= m_fire_next;
        m_seq_reg   <= m_seq_next;
        m_acked_reg <= m_acked_next;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_entries_reg <= RST_NUM_ENTRIES;
            start_code_reg  <= RST_START_CODE;
            base_code_reg   <= RST_BASE_CODE;
            ack_code_reg    <= RST_ACK_CODE;
            end_code_reg    <= RST_END_CODE;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_NUM_ENTRIES: num_entries_reg <= cfg_wr_data[NUM_ENT_W-1:0];
                REG_START_CODE:  start_code_reg  <= cfg_wr_data[BYTE_W-1:0];
                REG_BASE_CODE:   base_code_reg   <= cfg_wr_data[BYTE_W-1:0];
                REG_ACK_CODE:    ack_code_reg    <= cfg_wr_data[BYTE_W-1:0];
                REG_END_CODE:    end_code_reg    <= cfg_wr_data[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // result stream
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_acked_reg, m_seq_reg, m_fire_reg, m_ign_reg,
                       m_byte_reg, 1'b1};

    // every frame closes with the end code
    a_last_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (m_byte_reg == end_code_reg))
        else $error("frame closed without end code");

    // entry scan never runs past the entries in use
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TX_IGN || state_reg == ST_TX_FIRE) |-> (cnt_reg <= n_eff))
        else $error("entry scan out of range");

    // an acknowledged sequence sends nothing
    a_acked_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && in_op == OP_TRANSMIT && local_seq_reg == acked_reg)
        |=> (state_reg == ST_IDLE && !$rose(m_valid_reg)))
        else $error("frame sent for an acknowledged sequence");

    // fire classification always yields an index in range
    a_fire_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RX_FIRE) |-> (!alu_neg && alu_res < ALU_W'(n_eff)))
        else $error("fire code index out of range");

    // an ack frame only follows a data frame close
    a_ack_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACK_START && $past(state_reg) != ST_ACK_START)
        |-> ($past(state_reg) == ST_RX_CLASS && phase_reg == PHASE_HUNT))
        else $error("ack frame without a closed data frame");

endmodule : flag_state_sync_link
`default_nettype wire

### rtl/fls_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fls_alu
// shared add / subtract unit: builds frame codes and classifies received
// bytes against the code ranges; msb of the result is the sign
// ============================================================================
module fls_alu import fls_pkg::*; #(
    parameter int ALU_W = 10
) (
    input  wire logic [ALU_W-1:0] op_a,
    input  wire logic [ALU_W-1:0] op_b,
    input  wire logic             op_sub,
    output logic      [ALU_W-1:0] result
);

    logic [ALU_W-1:0] b_eff;

    // two's complement subtract through the same adder
    assign b_eff  = op_sub ? ~op_b : op_b;
    assign result = op_a + b_eff + ALU_W'(op_sub);

endmodule : fls_alu
`default_nettype wire

### verif/tb_flag_state_sync_link.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_flag_state_sync_link
// self-checking bench for the flag state sync link: a short table of
// directed items, then framed random traffic under several register
// settings; every result transfer is compared field by field against a
// local prediction of the flag, sequence and parser state
// ============================================================================
module tb_flag_state_sync_link;
    import fls_pkg::*;

    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int IDLE_LIMIT    = 3000;  // cycles without any transfer
    // index outside the register map, writes to it must be ignored
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

    // one predicted result transfer
    typedef struct packed {
        logic [BYTE_W-1:0]  tx_byte;
        logic               last;
        logic [FLAGS_W-1:0] ignite;
        logic [FLAGS_W-1:0] fire;
        logic [BYTE_W-1:0]  chg_seq;
        logic [BYTE_W-1:0]  ack_seq;
    } link_byte_t;

    // one directed stimulus row; typed rows carry a hand-written result
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [ENTRY_W-1:0] idx;
        logic               on;
        logic [BYTE_W-1:0]  rx;
        bit                 typed;
        int                 n_res;
        logic [BYTE_W-1:0]  last_byte;
    } stim_row_t;

    // dut signals, inputs driven to known values from time zero
    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic [S_TUSER_W-1:0]  s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    // register copies seen by the prediction
    logic [NUM_ENT_W-1:0] cfg_num_entries = RST_NUM_ENTRIES;
    logic [BYTE_W-1:0]    cfg_start       = RST_START_CODE;
    logic [BYTE_W-1:0]    cfg_base        = RST_BASE_CODE;
    logic [BYTE_W-1:0]    cfg_ack         = RST_ACK_CODE;
    logic [BYTE_W-1:0]    cfg_end         = RST_END_CODE;

    // predicted link state
    logic [FLS_MAX_ENTRIES-1:0] com_ign     = '0;
    logic [FLS_MAX_ENTRIES-1:0] com_fire    = '0;
    logic [FLS_MAX_ENTRIES-1:0] pend_ign    = '0;
    logic [FLS_MAX_ENTRIES-1:0] pend_fire   = '0;
    logic [BYTE_W-1:0]          local_seq   = '0;
    logic [BYTE_W-1:0]          partner_ack = '0;
    logic [BYTE_W-1:0]          frame_seq   = '0;
    phase_t                     rx_phase    = PHASE_HUNT;
    logic                       ack_flag    = 1'b0;

    link_byte_t outgoing_q[$];   // bytes still owed by the dut, oldest first
    link_byte_t fresh_q[$];      // bytes caused by the item just accepted
    stim_row_t  stim_rows[$];

    int fail_count    = 0;
    bit full_rate     = 1'b0;    // both sides run without gaps
    bit hold_request  = 1'b0;    // receiver takes one long hold-off

    flag_state_sync_link dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // 125 MHz clock
    initial begin
        forever #4 aclk = ~aclk;
    end

    // entries in use, counts above the built maximum saturate
    function automatic int entries_in_use();
        if (cfg_num_entries > FLS_MAX_ENTRIES) begin
            return FLS_MAX_ENTRIES;
        end
        return int'(cfg_num_entries);
    endfunction

    // apply one accepted item to the predicted state and collect its bytes in fresh_q
    task automatic advance_link_state(input logic [OP_W-1:0] op, input logic [ENTRY_W-1:0] idx,
                                      input logic on, input logic [BYTE_W-1:0] rx);
        logic [BYTE_W-1:0]  bytes_out[$];
        logic [FLAGS_W-1:0] ign_view;
        logic [FLAGS_W-1:0] fire_view;
        logic [31:0]        code;
        int unsigned        v;
        int unsigned        base_v;
        int                 n;
        link_byte_t         item;
        n = entries_in_use();
        fresh_q.delete();
        case (op)
            OP_SET_IGNITE: begin
                // only a real change bumps the sequence
                if (int'(idx) < n && com_ign[idx] != on) begin
                    com_ign[idx] = on;
                    local_seq = local_seq + 8'd1;
                end
            end
            OP_SET_FIRE: begin
                if (int'(idx) < n && com_fire[idx] != on) begin
                    com_fire[idx] = on;
                    local_seq = local_seq + 8'd1;
                end
            end
            OP_RX_BYTE: begin
                if (rx_phase == PHASE_SEQ) begin
                    frame_seq = rx;
                    ack_flag = 1'b0;
                    rx_phase = PHASE_BODY;
                end else if (rx_phase == PHASE_BODY) begin
                    // code ranges compared without wrap
                    v = rx;
                    base_v = cfg_base;
                    if (v >= base_v && v < base_v + n) begin
                        pend_ign[v - base_v] = 1'b1;
                    end else if (v >= base_v + n && v < base_v + 2 * n) begin
                        pend_fire[v - base_v - n] = 1'b1;
                    end else if (rx == cfg_ack) begin
                        partner_ack = frame_seq;
                        ack_flag = 1'b1;
                    end else if (rx == cfg_end) begin
                        // data frame: commit and answer with an ack frame
                        if (!ack_flag) begin
                            for (int i = 0; i < n; i++) begin
                                com_ign[i] = pend_ign[i];
                                com_fire[i] = pend_fire[i];
                                pend_ign[i] = 1'b0;
                                pend_fire[i] = 1'b0;
                            end
                            bytes_out.push_back(cfg_start);
                            bytes_out.push_back(frame_seq);
                            bytes_out.push_back(cfg_ack);
                            bytes_out.push_back(cfg_end);
                        end
                        rx_phase = PHASE_HUNT;
                    end else begin
                        // stray byte drops the pending set
                        for (int i = 0; i < n; i++) begin
                            pend_ign[i] = 1'b0;
                            pend_fire[i] = 1'b0;
                        end
                    end
                end else begin
                    rx_phase = (rx == cfg_start) ? PHASE_SEQ : PHASE_HUNT;
                end
            end
            default: begin
                // transmit only when the partner is behind
                if (local_seq != partner_ack) begin
                    bytes_out.push_back(cfg_start);
                    bytes_out.push_back(local_seq);
                    for (int i = 0; i < n; i++) begin
                        if (com_ign[i]) begin
                            code = cfg_base + i;
                            bytes_out.push_back(code[BYTE_W-1:0]);
                        end
                    end
                    for (int i = 0; i < n; i++) begin
                        if (com_fire[i]) begin
                            code = cfg_base + n + i;
                            bytes_out.push_back(code[BYTE_W-1:0]);
                        end
                    end
                    bytes_out.push_back(cfg_end);
                end
            end
        endcase
        // flags shown only for entries in use
        ign_view = '0;
        fire_view = '0;
        for (int i = 0; i < FLS_MAX_ENTRIES; i++) begin
            if (i < n) begin
                ign_view[i] = com_ign[i];
                fire_view[i] = com_fire[i];
            end
        end
        foreach (bytes_out[k]) begin
            item.tx_byte = bytes_out[k];
            item.last    = (k == bytes_out.size() - 1);
            item.ignite  = ign_view;
            item.fire    = fire_view;
            item.chg_seq = local_seq;
            item.ack_seq = partner_ack;
            fresh_q.push_back(item);
        end
    endtask

    // offer one item after a random gap, then log what it owes
    task automatic send_item(input logic [OP_W-1:0] op, input logic [ENTRY_W-1:0] idx,
                             input logic on, input logic [BYTE_W-1:0] rx,
                             input bit typed = 1'b0, input int n_res = 0,
                             input logic [BYTE_W-1:0] last_byte = 8'h00);
        int gap;
        gap = full_rate ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{S_PAD_W{1'b0}}, rx, on, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        advance_link_state(op, idx, on, rx);
        // hand-written rows override the prediction
        if (typed && n_res == 0) begin
            fresh_q.delete();
        end else if (typed && fresh_q.size() > 0) begin
            fresh_q[fresh_q.size() - 1].tx_byte = last_byte;
        end
        foreach (fresh_q[k]) outgoing_q.push_back(fresh_q[k]);
    endtask

    // received byte with junk in the unused fields
    task automatic send_rx(input logic [BYTE_W-1:0] b);
        logic [31:0] r;
        r = $urandom();
        send_item(OP_RX_BYTE, r[2:0], r[3], b);
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input logic [ENTRY_W-1:0] idx,
                           input logic on, input logic [BYTE_W-1:0] rx, input bit typed,
                           input int n_res, input logic [BYTE_W-1:0] last_byte);
        stim_row_t row;
        row.op = op;
        row.idx = idx;
        row.on = on;
        row.rx = rx;
        row.typed = typed;
        row.n_res = n_res;
        row.last_byte = last_byte;
        stim_rows.push_back(row);
    endtask

    // stop offering, wait for every owed byte, then let the block go quiet
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        wait (outgoing_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one register write, enable left high for back-to-back writes
    task automatic put_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= data;
        @(posedge aclk);
        case (addr)
            REG_NUM_ENTRIES: cfg_num_entries = data[NUM_ENT_W-1:0];
            REG_START_CODE:  cfg_start = data;
            REG_BASE_CODE:   cfg_base = data;
            REG_ACK_CODE:    cfg_ack = data;
            REG_END_CODE:    cfg_end = data;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [NUM_ENT_W-1:0] n_ent,
                                  input logic [BYTE_W-1:0] start_b, input logic [BYTE_W-1:0] base_b,
                                  input logic [BYTE_W-1:0] ack_b, input logic [BYTE_W-1:0] end_b);
        logic [31:0] r;
        r = $urandom();
        put_reg(REG_UNUSED, r[7:0]);
        // upper bits of the entry count are junk and must be masked
        put_reg(REG_NUM_ENTRIES, {r[11:8], n_ent});
        put_reg(REG_START_CODE, start_b);
        put_reg(REG_BASE_CODE, base_b);
        put_reg(REG_ACK_CODE, ack_b);
        put_reg(REG_END_CODE, end_b);
        cfg_wr_en <= 1'b0;
    endtask

    // random traffic, mostly well-formed frames with random content
    task automatic run_traffic(input int quota);
        int          sent;
        int          pick;
        int          n;
        int          k;
        int          slot;
        logic [31:0] r;
        logic [31:0] code;
        sent = 0;
        while (sent < quota) begin
            full_rate = (sent < 10);
            n = entries_in_use();
            pick = $urandom_range(0, 99);
            r = $urandom();
            if (pick < 30) begin
                // flag changes, indexes above the count included
                repeat ($urandom_range(1, 3)) begin
                    r = $urandom();
                    send_item(r[4] ? OP_SET_FIRE : OP_SET_IGNITE, r[2:0], r[3], r[12:5]);
                    sent++;
                end
            end else if (pick < 50) begin
                send_item(OP_TRANSMIT, r[2:0], r[3], r[11:4]);
                sent++;
            end else if (pick < 75) begin
                // data frame, sometimes with a stray byte or left open
                send_rx(cfg_start);
                send_rx(r[7:0]);
                k = $urandom_range(0, 2 * n);
                repeat (k) begin
                    r = $urandom();
                    slot = $urandom_range(0, 9);
                    if (slot < 8) begin
                        code = cfg_base + (r[8] ? n : 0) + $urandom_range(0, n - 1);
                        send_rx(code[BYTE_W-1:0]);
                    end else if (slot == 8) begin
                        send_rx(r[7:0]);
                    end else begin
                        send_rx(cfg_ack);
                    end
                end
                if ($urandom_range(0, 9) != 0) send_rx(cfg_end);
                sent += k + 3;
            end else if (pick < 90) begin
                // ack frame, often for the current sequence
                send_rx(cfg_start);
                send_rx(r[0] ? local_seq : r[15:8]);
                send_rx(cfg_ack);
                send_rx(cfg_end);
                sent += 4;
            end else begin
                // noise of any kind
                repeat ($urandom_range(1, 3)) begin
                    r = $urandom();
                    send_item(r[1:0], r[4:2], r[5], r[13:6]);
                    sent++;
                end
            end
        end
        full_rate = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endtask

    // result side: random stalls, one long hold-off on request, field checks
    initial begin : result_sink
        int                   stall;
        link_byte_t           want;
        logic [M_TDATA_W-1:0] got;
        logic                 got_last;
        wait (aresetn);
        forever begin
            if (hold_request) begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end else if (full_rate) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 9);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got = m_tdata;
            got_last = m_tlast;
            if (outgoing_q.size() == 0) begin
                $error("result transfer with nothing owed: m_tdata %h", got);
                fail_count++;
            end else begin
                want = outgoing_q.pop_front();
                check_field("byte_valid", 8'd1, {7'd0, got[0]});
                check_field("tx_byte", want.tx_byte, got[8:1]);
                check_field("last", {7'd0, want.last}, {7'd0, got_last});
                check_field("ignite_flags", want.ignite, got[16:9]);
                check_field("fire_flags", want.fire, got[24:17]);
                check_field("change_sequence", want.chg_seq, got[32:25]);
                check_field("acked_sequence", want.ack_seq, got[40:33]);
                check_field("m_tdata pad", 8'd0, {1'b0, got[47:41]});
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("tb_flag_state_sync_link: done, errors");
        $finish;
    end

    // stimulus and phase control
    initial begin : stimulus
        int          rn;
        logic [31:0] r;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table at reset settings: 8 entries, start 126, base 65, ack 33, end 10
        add_row(OP_TRANSMIT,   3'd0, 1'b0, 8'd0,   1'b1, 0, 8'd0);   // acknowledged after reset
        add_row(OP_SET_IGNITE, 3'd0, 1'b1, 8'd0,   1'b1, 0, 8'd0);
        add_row(OP_SET_IGNITE, 3'd0, 1'b1, 8'd0,   1'b1, 0, 8'd0);   // no change, no bump
        add_row(OP_SET_FIRE,   3'd7, 1'b1, 8'd0,   1'b1, 0, 8'd0);
        add_row(OP_SET_IGNITE, 3'd7, 1'b1, 8'd0,   1'b1, 0, 8'd0);
        add_row(OP_SET_IGNITE, 3'd0, 1'b0, 8'd0,   1'b1, 0, 8'd0);
        add_row(OP_SET_IGNITE, 3'd0, 1'b1, 8'd0,   1'b1, 0, 8'd0);
        add_row(OP_TRANSMIT,   3'd7, 1'b1, 8'd255, 1'b0, 0, 8'd0);   // full frame
        add_row(OP_RX_BYTE,    3'd0, 1'b0, 8'd0,   1'b0, 0, 8'd0);   // dropped while hunting
        add_row(OP_RX_BYTE,    3'd0, 1'b0, 8'd126, 1'b0, 0, 8'd0);
        add_row(OP_RX_BYTE,    3'd0, 1'b0, 8'd5,   1'b0, 0, 8'd0);
        add_row(OP_RX_BYTE,    3'd0, 1'b0, 8'd33,  1'b0, 0, 8'd0);   // ack for sequence 5
        add_row(OP_RX_BYTE,    3'd0, 1'b0, 8'd10,  1'b1, 0, 8'd0);   // acked frame, no reply
        add_row(OP_TRANSMIT,   3'd0, 1'b0, 8'd0,   1'b1, 0, 8'd0);   // partner up to date
        add_row(OP_RX_BYTE,    3'd7, 1'b1, 8'd255, 1'b0, 0, 8'd0);
        add_row(OP_RX_BYTE,    3'd0, 1'b0, 8'd126, 1'b0, 0, 8'd0);
        add_row(OP_RX_BYTE,    3'd0, 1'b0, 8'd200, 1'b0, 0, 8'd0);
        add_row(OP_RX_BYTE,    3'd0, 1'b0, 8'd65,  1'b0, 0, 8'd0);   // ignite 0
        add_row(OP_RX_BYTE,    3'd0, 1'b0, 8'd80,  1'b0, 0, 8'd0);   // fire 7
        add_row(OP_RX_BYTE,    3'd0, 1'b0, 8'd72,  1'b0, 0, 8'd0);   // ignite 7
        add_row(OP_RX_BYTE,    3'd0, 1'b0, 8'd10,  1'b1, 4, 8'd10);  // commit, ack frame
        add_row(OP_RX_BYTE,    3'd0, 1'b0, 8'd126, 1'b0, 0, 8'd0);
        add_row(OP_RX_BYTE,    3'd0, 1'b0, 8'd1,   1'b0, 0, 8'd0);
        add_row(OP_RX_BYTE,    3'd0, 1'b0, 8'd66,  1'b0, 0, 8'd0);
        add_row(OP_RX_BYTE,    3'd0, 1'b0, 8'd0,   1'b0, 0, 8'd0);   // stray byte clears pending
        add_row(OP_RX_BYTE,    3'd0, 1'b0, 8'd10,  1'b0, 0, 8'd0);   // commits all clear
        foreach (stim_rows[i]) begin
            send_item(stim_rows[i].op, stim_rows[i].idx, stim_rows[i].on, stim_rows[i].rx,
                      stim_rows[i].typed, stim_rows[i].n_res, stim_rows[i].last_byte);
        end
        drain_and_settle();

        run_traffic(60);
        drain_and_settle();

        // low codes, ack and end at the top
        apply_settings(4'd8, 8'd0, 8'd0, 8'd255, 8'd254);
        // fill the block while the receiver holds off
        hold_request = 1'b1;
        full_rate = 1'b1;
        repeat (6) begin
            r = $urandom();
            send_item(OP_SET_IGNITE, 3'd0, ~com_ign[0], r[7:0]);
            send_item(OP_TRANSMIT, r[10:8], r[11], r[19:12]);
        end
        full_rate = 1'b0;
        run_traffic(70);
        drain_and_settle();

        // single entry, fire code past 255 never matches
        apply_settings(4'd1, 8'd255, 8'd255, 8'd0, 8'd128);
        run_traffic(70);
        drain_and_settle();

        // fire codes at the top of the byte range
        apply_settings(4'd3, 8'd90, 8'd250, 8'd165, 8'd15);
        run_traffic(70);
        drain_and_settle();

        // random setting
        rn = $urandom_range(1, FLS_MAX_ENTRIES);
        r = $urandom();
        apply_settings(rn[NUM_ENT_W-1:0], r[7:0], r[15:8], r[23:16], r[31:24]);
        run_traffic(70);
        drain_and_settle();

        // fewer entries than stored flags
        apply_settings(4'd5, 8'd1, 8'd200, 8'd3, 8'd2);
        run_traffic(70);
        drain_and_settle();

        if (fail_count == 0) begin
            $display("tb_flag_state_sync_link: done, clean");
        end else begin
            $display("tb_flag_state_sync_link: done, errors");
        end
        $finish;
    end

endmodule
